@@ src/nll_pkg.sv @@
`default_nettype none
package nll_pkg;

    typedef enum logic [2:0] {
        K_INT = 3'd0,
        K_DBL = 3'd1,
        K_FLT = 3'd2,
        K_HEX = 3'd3,
        K_OCT = 3'd4,
        K_BIN = 3'd5
    } t_kind;

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_B  = 8'h62;
    localparam logic [7:0] CH_LC_E  = 8'h65;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_LC_X  = 8'h78;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_B  = 8'h42;
    localparam logic [7:0] CH_UC_E  = 8'h45;
    localparam logic [7:0] CH_UC_F  = 8'h46;
    localparam logic [7:0] CH_UC_X  = 8'h58;

    localparam logic [7:0] LEN_MAX  = 8'hFF;

    typedef struct packed {
        logic [7:0] chr;
        logic       first;
        logic       last;
    } t_item;

    typedef struct packed {
        logic        char_taken;
        logic [63:0] int_value;
        logic [7:0]  token_length;
        t_kind       kind;
        logic        valid_res;
    } t_result;

endpackage
`default_nettype wire

@@ src/nll_core.sv @@
`default_nettype none
module nll_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire nll_pkg::t_item   i_item,
    output logic                  o_has_res,
    output nll_pkg::t_result      o_res
);

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_SIGN  = 4'd1,
        PH_INT   = 4'd2,
        PH_FRAC  = 4'd3,
        PH_ESIGN = 4'd4,
        PH_EXP   = 4'd5,
        PH_ZERO  = 4'd6,
        PH_OCT   = 4'd7,
        PH_HEX   = 4'd8,
        PH_BIN   = 4'd9,
        PH_START = 4'd10
    } t_phase;

    t_phase          r_phase,  n_phase;
    logic            r_neg,    n_neg;
    logic [63:0]     r_acc,    n_acc;
    logic [7:0]      r_len,    n_len;
    nll_pkg::t_kind  r_kind,   n_kind;

    logic        take;
    logic        stop;
    logic        active;
    logic        is_dig;
    logic        is_oct;
    logic        is_e;
    logic        is_f;
    logic        is_hex;
    logic [3:0]  hex_val;
    logic [3:0]  dig_val;
    logic [31:0] oct_word;
    logic [7:0]  c;

    always_comb begin
        c       = i_item.chr;
        dig_val = 4'(c - nll_pkg::CH_0);
        is_dig  = (c >= nll_pkg::CH_0) && (c <= nll_pkg::CH_9);
        is_oct  = (c >= nll_pkg::CH_0) && (c <= nll_pkg::CH_7);
        is_e    = (c == nll_pkg::CH_LC_E) || (c == nll_pkg::CH_UC_E);
        is_f    = (c == nll_pkg::CH_LC_F) || (c == nll_pkg::CH_UC_F);
        is_hex  = is_dig
               || ((c >= nll_pkg::CH_LC_A) && (c <= nll_pkg::CH_LC_F))
               || ((c >= nll_pkg::CH_UC_A) && (c <= nll_pkg::CH_UC_F));
        hex_val = is_dig ? dig_val : 4'(c[3:0] + 4'd9);

        n_phase = r_phase;
        n_neg   = r_neg;
        n_acc   = r_acc;
        n_len   = r_len;
        n_kind  = r_kind;
        active  = 1'b1;
        take    = 1'b0;
        stop    = 1'b0;

        if (i_item.first) begin
            n_phase = PH_START;
            n_neg   = 1'b0;
            n_acc   = '0;
            n_len   = '0;
            n_kind  = nll_pkg::K_INT;
        end else if (r_phase == PH_IDLE || r_phase > PH_BIN) begin
            n_phase = PH_IDLE;
            active  = 1'b0;
        end

        unique case (n_phase)
            PH_START, PH_SIGN: begin
                if (n_phase == PH_START
                    && (c == nll_pkg::CH_MINUS || c == nll_pkg::CH_PLUS)) begin
                    n_neg   = (c == nll_pkg::CH_MINUS);
                    n_phase = PH_SIGN;
                    take    = 1'b1;
                end else if (is_dig) begin
                    n_acc   = {60'd0, dig_val};
                    n_phase = (c == nll_pkg::CH_0) ? PH_ZERO : PH_INT;
                    n_kind  = nll_pkg::K_INT;
                    take    = 1'b1;
                end
            end
            PH_INT: begin
                if (is_dig) begin
                    n_acc = (r_acc << 3) + (r_acc << 1) + {60'd0, dig_val};
                    take  = 1'b1;
                end else if (c == nll_pkg::CH_DOT) begin
                    n_phase = PH_FRAC;
                    n_kind  = nll_pkg::K_DBL;
                    take    = 1'b1;
                end else if (is_e) begin
                    n_phase = PH_ESIGN;
                    n_kind  = nll_pkg::K_DBL;
                    take    = 1'b1;
                end
            end
            PH_FRAC: begin
                if (is_dig) begin
                    take = 1'b1;
                end else if (is_e) begin
                    n_phase = PH_ESIGN;
                    n_kind  = nll_pkg::K_DBL;
                    take    = 1'b1;
                end
            end
            PH_ESIGN, PH_EXP: begin
                if (is_dig || (n_phase == PH_ESIGN
                    && (c == nll_pkg::CH_PLUS || c == nll_pkg::CH_MINUS))) begin
                    n_phase = PH_EXP;
                    take    = 1'b1;
                end else if (is_f) begin
                    n_kind = nll_pkg::K_FLT;
                    take   = 1'b1;
                    stop   = 1'b1;
                end
            end
            PH_ZERO: begin
                if (c == nll_pkg::CH_LC_X || c == nll_pkg::CH_UC_X) begin
                    n_phase = PH_HEX;
                    n_kind  = nll_pkg::K_HEX;
                    take    = 1'b1;
                end else if (c == nll_pkg::CH_LC_B || c == nll_pkg::CH_UC_B) begin
                    n_phase = PH_BIN;
                    n_kind  = nll_pkg::K_BIN;
                    take    = 1'b1;
                end else if (is_oct) begin
                    n_phase = PH_OCT;
                    n_kind  = nll_pkg::K_OCT;
                    n_acc   = {r_acc[60:0], dig_val[2:0]};
                    take    = 1'b1;
                end else if (c == nll_pkg::CH_DOT) begin
                    n_phase = PH_FRAC;
                    n_kind  = nll_pkg::K_DBL;
                    take    = 1'b1;
                end
            end
            PH_OCT: begin
                if (is_oct) begin
                    n_acc = {r_acc[60:0], dig_val[2:0]};
                    take  = 1'b1;
                end
            end
            PH_HEX: begin
                if (is_hex) begin
                    n_acc = {r_acc[59:0], hex_val};
                    take  = 1'b1;
                end
            end
            PH_BIN: begin
                if (c == nll_pkg::CH_0 || c == nll_pkg::CH_1) begin
                    n_acc = {r_acc[62:0], c[0]};
                    take  = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (take && n_len != nll_pkg::LEN_MAX) begin
            n_len = n_len + 8'd1;
        end

        o_has_res = active && (!take || stop || i_item.last);

        o_res.valid_res    = (n_phase != PH_START) && (n_phase != PH_SIGN);
        o_res.kind         = o_res.valid_res ? n_kind : nll_pkg::K_INT;
        o_res.token_length = n_len;
        o_res.char_taken   = take;
        oct_word           = n_neg ? 32'(-n_acc[31:0]) : n_acc[31:0];
        if (!o_res.valid_res || n_kind == nll_pkg::K_DBL || n_kind == nll_pkg::K_FLT) begin
            o_res.int_value = '0;
        end else if (n_kind == nll_pkg::K_OCT) begin
            o_res.int_value = {{32{oct_word[31]}}, oct_word};
        end else begin
            o_res.int_value = n_neg ? -n_acc : n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && o_has_res)) begin
            r_phase <= PH_IDLE;
            r_neg   <= 1'b0;
            r_acc   <= '0;
            r_len   <= '0;
            r_kind  <= nll_pkg::K_INT;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_acc   <= n_acc;
            r_len   <= n_len;
            r_kind  <= n_kind;
        end
    end

endmodule
`default_nettype wire

@@ src/numeric_literal_lexer_top.sv @@
// Numeric literal lexer: scans a character stream one byte per beat and
// reports each C-style numeric literal (decimal, octal, hex, binary, float).
// Input channel (s_axis): tdata carries the character, tuser marks the first
// character of a new literal, tlast marks the final character of the text.
// Output channel (m_axis): one beat per finished token, carrying validity,
// token length, the wrapped 64-bit integer value (octal: 32-bit, sign-extended)
// and whether the ending character was consumed; tuser carries the literal kind.
// Results are registered: the character that ends the token passes the input
// register, then the result register, before its beat appears on m_axis.
// Throughput: one character per cycle while the receiver keeps up, set by the single
// state update that runs between the input register and the result register.
// A stalled receiver holds the result register; the beat in the input
// register then waits as well, and further input stalls until the pending
// result is taken.
// Reset (synchronous, active low) drops any open literal and pending beats.
`default_nettype none
module numeric_literal_lexer_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] chr
    input  wire logic        i_s_axis_tuser,   // [0] first
    input  wire logic        i_s_axis_tlast,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [79:0]      o_m_axis_tdata,   // [0] valid_res, [8:1] token_length,
                                               // [72:9] int_value, [73] char_taken
    output logic [2:0]       o_m_axis_tuser    // [2:0] kind
);

    logic             r_in_valid;
    nll_pkg::t_item   r_in_item;
    logic             r_out_valid;
    nll_pkg::t_result r_out_res;

    logic             step;
    logic             has_res;
    nll_pkg::t_result res;

    assign step            = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || step;

    nll_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_item    (r_in_item),
        .o_has_res (has_res),
        .o_res     (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (step && has_res) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_item.chr   <= i_s_axis_tdata;
            r_in_item.first <= i_s_axis_tuser;
            r_in_item.last  <= i_s_axis_tlast;
        end
        if (step && has_res) begin
            r_out_res <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out_res.char_taken, r_out_res.int_value,
                              r_out_res.token_length, r_out_res.valid_res};
    assign o_m_axis_tuser  = r_out_res.kind;

endmodule
`default_nettype wire

@@ src/nll_checker.sv @@
`default_nettype none
module nll_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    input  wire logic [79:0] o_m_axis_tdata,
    input  wire logic [2:0]  o_m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result beat changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result beat right after reset");

    a_invalid_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tdata[0] |->
            o_m_axis_tuser == nll_pkg::K_INT && o_m_axis_tdata[72:9] == 64'd0
            && o_m_axis_tdata[8:1] <= 8'd1)
        else $error("invalid token carries kind, value or length");

    a_float_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == nll_pkg::K_DBL
            || o_m_axis_tuser == nll_pkg::K_FLT) |->
            o_m_axis_tdata[72:9] == 64'd0)
        else $error("float token carries an integer value");

    a_valid_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[0] |-> o_m_axis_tdata[8:1] != 8'd0)
        else $error("valid token of zero length");

endmodule

bind numeric_literal_lexer_top nll_checker u_nll_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
`default_nettype wire

@@ tb/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [3:0] {
        SC_IDLE,
        SC_SIGN,
        SC_INT,
        SC_FRAC,
        SC_ESIGN,
        SC_EXP,
        SC_ZERO,
        SC_OCT,
        SC_HEX,
        SC_BIN,
        SC_START
    } t_scan;

    class literal_checker;
        t_scan            scan;
        logic             neg;
        logic [63:0]      acc;
        logic [7:0]       taken_cnt;
        nll_pkg::t_kind   kind_now;
        nll_pkg::t_result pending_tokens[$];
        int               errors;

        function new();
            clear();
            errors = 0;
        endfunction

        function void clear();
            scan      = SC_IDLE;
            neg       = 1'b0;
            acc       = '0;
            taken_cnt = '0;
            kind_now  = nll_pkg::K_INT;
        endfunction

        function bit is_dec(logic [7:0] c);
            return c >= nll_pkg::CH_0 && c <= nll_pkg::CH_9;
        endfunction

        function int hex_digit(logic [7:0] c);
            if (c >= nll_pkg::CH_0 && c <= nll_pkg::CH_9) return c - nll_pkg::CH_0;
            if (c >= nll_pkg::CH_LC_A && c <= nll_pkg::CH_LC_F)
                return c - nll_pkg::CH_LC_A + 10;
            if (c >= nll_pkg::CH_UC_A && c <= nll_pkg::CH_UC_F)
                return c - nll_pkg::CH_UC_A + 10;
            return -1;
        endfunction

        function void start_digits(logic [7:0] c);
            acc      = 64'(c - nll_pkg::CH_0);
            scan     = (c == nll_pkg::CH_0) ? SC_ZERO : SC_INT;
            kind_now = nll_pkg::K_INT;
        endfunction

        function logic [63:0] token_value();
            logic [31:0] w;
            if (kind_now == nll_pkg::K_OCT) begin
                w = neg ? -acc[31:0] : acc[31:0];
                return {{32{w[31]}}, w};
            end
            if (kind_now == nll_pkg::K_DBL || kind_now == nll_pkg::K_FLT) return '0;
            return neg ? -acc : acc;
        endfunction

        function void note_char(logic [7:0] c, logic f, logic l);
            logic             take;
            logic             stop;
            int               h;
            nll_pkg::t_result r;
            take = 1'b0;
            stop = 1'b0;
            if (f) begin
                clear();
                scan = SC_START;
            end else if (scan == SC_IDLE || scan > SC_BIN) begin
                scan = SC_IDLE;
                return;
            end
            case (scan)
                SC_START: begin
                    if (c == nll_pkg::CH_MINUS || c == nll_pkg::CH_PLUS) begin
                        neg  = (c == nll_pkg::CH_MINUS);
                        scan = SC_SIGN;
                        take = 1'b1;
                    end else if (is_dec(c)) begin
                        start_digits(c);
                        take = 1'b1;
                    end
                end
                SC_SIGN: begin
                    if (is_dec(c)) begin
                        start_digits(c);
                        take = 1'b1;
                    end
                end
                SC_INT: begin
                    if (is_dec(c)) begin
                        acc  = acc * 10 + 64'(c - nll_pkg::CH_0);
                        take = 1'b1;
                    end else if (c == nll_pkg::CH_DOT) begin
                        scan = SC_FRAC; kind_now = nll_pkg::K_DBL; take = 1'b1;
                    end else if (c == nll_pkg::CH_LC_E || c == nll_pkg::CH_UC_E) begin
                        scan = SC_ESIGN; kind_now = nll_pkg::K_DBL; take = 1'b1;
                    end
                end
                SC_FRAC: begin
                    if (is_dec(c)) begin
                        take = 1'b1;
                    end else if (c == nll_pkg::CH_LC_E || c == nll_pkg::CH_UC_E) begin
                        scan = SC_ESIGN; kind_now = nll_pkg::K_DBL; take = 1'b1;
                    end
                end
                SC_ESIGN, SC_EXP: begin
                    if (is_dec(c) || (scan == SC_ESIGN
                        && (c == nll_pkg::CH_PLUS || c == nll_pkg::CH_MINUS))) begin
                        scan = SC_EXP; take = 1'b1;
                    end else if (c == nll_pkg::CH_LC_F || c == nll_pkg::CH_UC_F) begin
                        kind_now = nll_pkg::K_FLT; take = 1'b1; stop = 1'b1;
                    end
                end
                SC_ZERO: begin
                    if (c == nll_pkg::CH_LC_X || c == nll_pkg::CH_UC_X) begin
                        scan = SC_HEX; kind_now = nll_pkg::K_HEX; take = 1'b1;
                    end else if (c == nll_pkg::CH_LC_B || c == nll_pkg::CH_UC_B) begin
                        scan = SC_BIN; kind_now = nll_pkg::K_BIN; take = 1'b1;
                    end else if (c >= nll_pkg::CH_0 && c <= nll_pkg::CH_7) begin
                        scan = SC_OCT; kind_now = nll_pkg::K_OCT;
                        acc  = acc * 8 + 64'(c - nll_pkg::CH_0);
                        take = 1'b1;
                    end else if (c == nll_pkg::CH_DOT) begin
                        scan = SC_FRAC; kind_now = nll_pkg::K_DBL; take = 1'b1;
                    end
                end
                SC_OCT: begin
                    if (c >= nll_pkg::CH_0 && c <= nll_pkg::CH_7) begin
                        acc  = acc * 8 + 64'(c - nll_pkg::CH_0);
                        take = 1'b1;
                    end
                end
                SC_HEX: begin
                    h = hex_digit(c);
                    if (h >= 0) begin
                        acc  = {acc[59:0], h[3:0]};
                        take = 1'b1;
                    end
                end
                SC_BIN: begin
                    if (c == nll_pkg::CH_0 || c == nll_pkg::CH_1) begin
                        acc  = {acc[62:0], c[0]};
                        take = 1'b1;
                    end
                end
                default: ;
            endcase
            if (take && taken_cnt != nll_pkg::LEN_MAX) taken_cnt++;
            if (take && !stop && !l) return;
            r.valid_res    = (scan != SC_START && scan != SC_SIGN);
            r.kind         = r.valid_res ? kind_now : nll_pkg::K_INT;
            r.token_length = taken_cnt;
            r.int_value    = r.valid_res ? token_value() : '0;
            r.char_taken   = take;
            pending_tokens.push_back(r);
            clear();
        endfunction

        function void field_check(string name, logic [63:0] exp_v, logic [63:0] act_v);
            if (exp_v !== act_v) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_token(logic [79:0] d, logic [2:0] k);
            nll_pkg::t_result e;
            if (pending_tokens.size() == 0) begin
                $display("%0t: unexpected token, expected none, actual tdata %h kind %0d",
                         $time, d, k);
                errors++;
                return;
            end
            e = pending_tokens.pop_front();
            field_check("valid_res", 64'(e.valid_res), 64'(d[0]));
            field_check("kind", 64'(e.kind), 64'(k));
            field_check("token_length", 64'(e.token_length), 64'(d[8:1]));
            field_check("int_value", e.int_value, d[72:9]);
            field_check("char_taken", 64'(e.char_taken), 64'(d[73]));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata = '0;
    logic        i_s_axis_tuser = 1'b0;
    logic        i_s_axis_tlast = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [79:0] o_m_axis_tdata;
    logic [2:0]  o_m_axis_tuser;

    literal_checker sb = new();
    int             n_items = 0;
    int             send_idle_pct = 17;
    int             recv_idle_pct = 83;
    logic [7:0]     lit_chars[$];

    numeric_literal_lexer_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (o_m_axis_tvalid && i_m_axis_tready) begin
            sb.check_token(o_m_axis_tdata, o_m_axis_tuser);
        end
        i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_char(input logic [7:0] c, input logic f, input logic l);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= c;
        i_s_axis_tuser  <= f;
        i_s_axis_tlast  <= l;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_char(c, f, l);
        n_items++;
    endtask

    task automatic send_str(input string s, input bit end_last);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i], i == 0, end_last && i == s.len() - 1);
        end
    endtask

    function automatic logic [7:0] rand_digit(int radix);
        int v;
        v = $urandom_range(radix - 1);
        if (v < 10) return 8'(nll_pkg::CH_0 + v);
        return 8'(($urandom_range(1) ? nll_pkg::CH_LC_A : nll_pkg::CH_UC_A) + v - 10);
    endfunction

    function automatic logic [7:0] rand_lexeme_char();
        case ($urandom_range(9))
            0: return nll_pkg::CH_DOT;
            1: return $urandom_range(1) ? nll_pkg::CH_LC_E : nll_pkg::CH_UC_E;
            2: return $urandom_range(1) ? nll_pkg::CH_LC_F : nll_pkg::CH_UC_F;
            3: return $urandom_range(1) ? nll_pkg::CH_LC_X : nll_pkg::CH_UC_X;
            4: return $urandom_range(1) ? nll_pkg::CH_LC_B : nll_pkg::CH_UC_B;
            5: return $urandom_range(1) ? nll_pkg::CH_PLUS : nll_pkg::CH_MINUS;
            default: return rand_digit(10);
        endcase
    endfunction

    function automatic void add_exponent();
        lit_chars.push_back($urandom_range(1) ? nll_pkg::CH_LC_E : nll_pkg::CH_UC_E);
        case ($urandom_range(2))
            1: lit_chars.push_back(nll_pkg::CH_PLUS);
            2: lit_chars.push_back(nll_pkg::CH_MINUS);
            default: ;
        endcase
        repeat ($urandom_range(3)) lit_chars.push_back(rand_digit(10));
        if ($urandom_range(1))
            lit_chars.push_back($urandom_range(1) ? nll_pkg::CH_LC_F : nll_pkg::CH_UC_F);
    endfunction

    function automatic void fill_literal();
        int n;
        lit_chars.delete();
        case ($urandom_range(3))
            1: lit_chars.push_back(nll_pkg::CH_PLUS);
            2: lit_chars.push_back(nll_pkg::CH_MINUS);
            default: ;
        endcase
        n = ($urandom_range(7) == 0) ? $urandom_range(17, 30) : $urandom_range(6);
        case ($urandom_range(7))
            0: begin
                lit_chars.push_back(8'(nll_pkg::CH_1 + $urandom_range(8)));
                repeat (n) lit_chars.push_back(rand_digit(10));
            end
            1: begin
                lit_chars.push_back(nll_pkg::CH_0);
                repeat (n) lit_chars.push_back(rand_digit(8));
            end
            2: begin
                lit_chars.push_back(nll_pkg::CH_0);
                lit_chars.push_back($urandom_range(1) ? nll_pkg::CH_LC_X : nll_pkg::CH_UC_X);
                repeat (n) lit_chars.push_back(rand_digit(16));
            end
            3: begin
                lit_chars.push_back(nll_pkg::CH_0);
                lit_chars.push_back($urandom_range(1) ? nll_pkg::CH_LC_B : nll_pkg::CH_UC_B);
                repeat (3 * n) lit_chars.push_back(rand_digit(2));
            end
            4: begin
                repeat (n + 1) lit_chars.push_back(rand_digit(10));
                lit_chars.push_back(nll_pkg::CH_DOT);
                repeat (n) lit_chars.push_back(rand_digit(10));
                if ($urandom_range(1)) add_exponent();
            end
            5: begin
                repeat (n + 1) lit_chars.push_back(rand_digit(10));
                add_exponent();
            end
            6: begin
                lit_chars.push_back(nll_pkg::CH_0);
                case ($urandom_range(2))
                    0: lit_chars.push_back(nll_pkg::CH_9);
                    1: lit_chars.push_back(8'(nll_pkg::CH_7 + 1));
                    default: lit_chars.push_back($urandom_range(1) ? nll_pkg::CH_LC_E
                                                                   : nll_pkg::CH_UC_E);
                endcase
            end
            default: begin
                repeat (n + 1) lit_chars.push_back(rand_lexeme_char());
            end
        endcase
    endfunction

    task automatic send_literal();
        int ending;
        fill_literal();
        if ($urandom_range(7) == 0) begin
            lit_chars[$urandom_range(lit_chars.size() - 1)] = 8'($urandom_range(255));
        end
        ending = $urandom_range(2);
        if (ending == 1) lit_chars.push_back(8'($urandom_range(255)));
        foreach (lit_chars[i]) begin
            send_char(lit_chars[i], i == 0, ending == 0 && i == lit_chars.size() - 1);
        end
    endtask

    task automatic run_phase(input int sidle, input int ridle, input int target);
        int start_cnt;
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        start_cnt = n_items;
        while (n_items - start_cnt < target) begin
            if ($urandom_range(9) < 8) begin
                send_literal();
            end else begin
                send_char(8'($urandom_range(255)), $urandom_range(3) == 0,
                          $urandom_range(7) == 0);
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_char(8'hFF, 1'b1, 1'b0);
        send_char(8'h00, 1'b0, 1'b0);
        send_str("-", 1'b1);
        send_str("+a", 1'b0);
        send_str("09", 1'b0);
        send_str("0X", 1'b1);
        send_str("7.E+3F", 1'b0);
        send_str("0B1", 1'b1);
        send_str("-0178", 1'b0);
        send_str("35", 1'b0);
        send_str("0xaF", 1'b1);

        run_phase(17, 83, 290);
        run_phase(83, 17, 290);
        run_phase(0, 0, 270);

        // overlong hex literal: value wraps, length saturates
        lit_chars.delete();
        lit_chars.push_back(nll_pkg::CH_0);
        lit_chars.push_back(nll_pkg::CH_LC_X);
        repeat (270) lit_chars.push_back(rand_digit(16));
        foreach (lit_chars[i]) send_char(lit_chars[i], i == 0, i == lit_chars.size() - 1);
        i_s_axis_tvalid <= 1'b0;

        while (sb.pending_tokens.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_tokens.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
